### rtl/acc_alu_pkg.sv
// -----------------------------------------------------------------------------
// acc_alu_pkg
// Operation codes, flag bit positions and small flag helpers shared by the
// accumulator ALU and its checker.
// -----------------------------------------------------------------------------
package acc_alu_pkg;

   localparam int unsigned ACTION_W = 5;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned WIDE_W   = 16;

   // flag bit positions
   localparam int unsigned FLAG_S = 7;
   localparam int unsigned FLAG_Z = 6;
   localparam int unsigned FLAG_Y = 5;
   localparam int unsigned FLAG_H = 4;
   localparam int unsigned FLAG_X = 3;
   localparam int unsigned FLAG_P = 2;
   localparam int unsigned FLAG_N = 1;
   localparam int unsigned FLAG_C = 0;

   localparam logic [BYTE_W-1:0] DAA_HIGH_LIMIT = 8'h99;
   localparam logic [BYTE_W-1:0] DAA_HIGH_ADJ   = 8'h60;
   localparam logic [BYTE_W-1:0] DAA_LOW_ADJ    = 8'h06;
   localparam logic [3:0]        DAA_LOW_LIMIT  = 4'h9;
   localparam logic [3:0]        DAA_SUB_LIMIT  = 4'h5;
   localparam logic [BYTE_W-1:0] INC_OVF_VALUE  = 8'h80;
   localparam logic [BYTE_W-1:0] DEC_OVF_VALUE  = 8'h7f;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD   = 5'd0,
      ACT_ADC   = 5'd1,
      ACT_SUB   = 5'd2,
      ACT_SBC   = 5'd3,
      ACT_AND   = 5'd4,
      ACT_XOR   = 5'd5,
      ACT_OR    = 5'd6,
      ACT_CP    = 5'd7,
      ACT_INC   = 5'd8,
      ACT_DEC   = 5'd9,
      ACT_DAA   = 5'd10,
      ACT_CPL   = 5'd11,
      ACT_SCF   = 5'd12,
      ACT_CCF   = 5'd13,
      ACT_RLCA  = 5'd14,
      ACT_RRCA  = 5'd15,
      ACT_RLA   = 5'd16,
      ACT_RRA   = 5'd17,
      ACT_ADD16 = 5'd18
   } action_type;

   // sign, zero and the two copied bits of a result byte
   function automatic logic [BYTE_W-1:0] szxy_flags(input logic [BYTE_W-1:0] r);
      logic [BYTE_W-1:0] f;
      f         = '0;
      f[FLAG_S] = r[FLAG_S];
      f[FLAG_Y] = r[FLAG_Y];
      f[FLAG_X] = r[FLAG_X];
      f[FLAG_Z] = (r == '0);
      return f;
   endfunction

   // set on even parity
   function automatic logic even_parity(input logic [BYTE_W-1:0] r);
      return ~(^r);
   endfunction

endpackage

### rtl/acc_alu_core.sv
// -----------------------------------------------------------------------------
// acc_alu_core
// Combinational datapath of the accumulator ALU: one shared byte adder, the
// logic operations, decimal adjust, rotates and the 16-bit add.
// -----------------------------------------------------------------------------
module acc_alu_core
   import acc_alu_pkg::*;
(
   input  logic [ACTION_W-1:0] action,
   input  logic [BYTE_W-1:0]   acc_in,
   input  logic [BYTE_W-1:0]   flags_in,
   input  logic [BYTE_W-1:0]   operand,
   input  logic [WIDE_W-1:0]   wide_left,
   input  logic [WIDE_W-1:0]   wide_right,
   output logic [BYTE_W-1:0]   result,
   output logic [BYTE_W-1:0]   flags_out,
   output logic [WIDE_W-1:0]   wide_result
);

   action_type          act;
   logic                cin;
   logic                use_cin;
   logic                is_sub;
   logic [BYTE_W:0]     sum9;
   logic [BYTE_W-1:0]   sum_r;
   logic [BYTE_W-1:0]   arith_f;
   logic [BYTE_W-1:0]   inc_r;
   logic [BYTE_W-1:0]   dec_r;
   logic                daa_hi;
   logic                daa_lo;
   logic [BYTE_W-1:0]   daa_diff;
   logic [BYTE_W-1:0]   daa_r;
   logic                daa_h;
   logic [WIDE_W:0]     sum17;
   logic [WIDE_W-1:0]   w16;
   logic [BYTE_W-1:0]   logic_r;
   logic [BYTE_W-1:0]   rot_r;
   logic [BYTE_W-1:0]   keep_szp;

   assign act      = action_type'(action);
   assign cin      = flags_in[FLAG_C];
   assign use_cin  = (act == ACT_ADC) || (act == ACT_SBC);
   assign is_sub   = (act == ACT_SUB) || (act == ACT_SBC) || (act == ACT_CP);

   // shared byte adder for add, adc, sub, sbc and cp
   always_comb begin
      if (is_sub) begin
         sum9 = {1'b0, acc_in} - {1'b0, operand} - {{BYTE_W{1'b0}}, use_cin & cin};
      end else begin
         sum9 = {1'b0, acc_in} + {1'b0, operand} + {{BYTE_W{1'b0}}, use_cin & cin};
      end
      sum_r          = sum9[BYTE_W-1:0];
      arith_f        = szxy_flags(sum_r);
      arith_f[FLAG_H] = acc_in[4] ^ operand[4] ^ sum_r[4];
      arith_f[FLAG_C] = sum9[BYTE_W];
      arith_f[FLAG_N] = is_sub;
      if (is_sub) begin
         arith_f[FLAG_P] = (acc_in[7] ^ operand[7]) & (acc_in[7] ^ sum_r[7]);
      end else begin
         arith_f[FLAG_P] = ~(acc_in[7] ^ operand[7]) & (acc_in[7] ^ sum_r[7]);
      end
   end

   assign inc_r = operand + 8'd1;
   assign dec_r = operand - 8'd1;

   // decimal adjust
   always_comb begin
      daa_hi   = cin || (acc_in > DAA_HIGH_LIMIT);
      daa_lo   = flags_in[FLAG_H] || (acc_in[3:0] > DAA_LOW_LIMIT);
      daa_diff = (daa_hi ? DAA_HIGH_ADJ : '0) | (daa_lo ? DAA_LOW_ADJ : '0);
      if (flags_in[FLAG_N]) begin
         daa_h = flags_in[FLAG_H] && (acc_in[3:0] <= DAA_SUB_LIMIT);
         daa_r = acc_in - daa_diff;
      end else begin
         daa_h = acc_in[3:0] > DAA_LOW_LIMIT;
         daa_r = acc_in + daa_diff;
      end
   end

   assign sum17 = {1'b0, wide_left} + {1'b0, wide_right};
   assign w16   = sum17[WIDE_W-1:0];

   assign keep_szp = flags_in & ((BYTE_W'(1) << FLAG_S) | (BYTE_W'(1) << FLAG_Z)
                                 | (BYTE_W'(1) << FLAG_P));

   always_comb begin
      result      = acc_in;
      flags_out   = flags_in;
      wide_result = '0;
      logic_r     = '0;
      rot_r       = '0;
      case (act)
         ACT_ADD, ACT_ADC, ACT_SUB, ACT_SBC: begin
            result    = sum_r;
            flags_out = arith_f;
         end
         ACT_CP: begin
            flags_out         = arith_f;
            flags_out[FLAG_Y] = operand[FLAG_Y];
            flags_out[FLAG_X] = operand[FLAG_X];
         end
         ACT_AND, ACT_XOR, ACT_OR: begin
            if (act == ACT_AND) begin
               logic_r = acc_in & operand;
            end else if (act == ACT_XOR) begin
               logic_r = acc_in ^ operand;
            end else begin
               logic_r = acc_in | operand;
            end
            result            = logic_r;
            flags_out         = szxy_flags(logic_r);
            flags_out[FLAG_P] = even_parity(logic_r);
            flags_out[FLAG_H] = (act == ACT_AND);
         end
         ACT_INC: begin
            result            = inc_r;
            flags_out         = szxy_flags(inc_r);
            flags_out[FLAG_C] = cin;
            flags_out[FLAG_P] = (inc_r == INC_OVF_VALUE);
            flags_out[FLAG_H] = (inc_r[3:0] == 4'h0);
         end
         ACT_DEC: begin
            result            = dec_r;
            flags_out         = szxy_flags(dec_r);
            flags_out[FLAG_C] = cin;
            flags_out[FLAG_N] = 1'b1;
            flags_out[FLAG_P] = (dec_r == DEC_OVF_VALUE);
            flags_out[FLAG_H] = (dec_r[3:0] == 4'hf);
         end
         ACT_DAA: begin
            result            = daa_r;
            flags_out         = szxy_flags(daa_r);
            flags_out[FLAG_P] = even_parity(daa_r);
            flags_out[FLAG_H] = daa_h;
            flags_out[FLAG_N] = flags_in[FLAG_N];
            flags_out[FLAG_C] = daa_hi;
         end
         ACT_CPL: begin
            result            = ~acc_in;
            flags_out         = keep_szp;
            flags_out[FLAG_C] = cin;
            flags_out[FLAG_H] = 1'b1;
            flags_out[FLAG_N] = 1'b1;
            flags_out[FLAG_Y] = ~acc_in[FLAG_Y];
            flags_out[FLAG_X] = ~acc_in[FLAG_X];
         end
         ACT_SCF, ACT_CCF: begin
            flags_out         = keep_szp;
            flags_out[FLAG_Y] = acc_in[FLAG_Y];
            flags_out[FLAG_X] = acc_in[FLAG_X];
            if (act == ACT_SCF) begin
               flags_out[FLAG_C] = 1'b1;
            end else begin
               flags_out[FLAG_H] = cin;
               flags_out[FLAG_C] = ~cin;
            end
         end
         ACT_RLCA, ACT_RLA, ACT_RRCA, ACT_RRA: begin
            if (act == ACT_RLCA) begin
               rot_r = {acc_in[6:0], acc_in[7]};
            end else if (act == ACT_RLA) begin
               rot_r = {acc_in[6:0], cin};
            end else if (act == ACT_RRCA) begin
               rot_r = {acc_in[0], acc_in[7:1]};
            end else begin
               rot_r = {cin, acc_in[7:1]};
            end
            result            = rot_r;
            flags_out         = keep_szp;
            flags_out[FLAG_Y] = rot_r[FLAG_Y];
            flags_out[FLAG_X] = rot_r[FLAG_X];
            flags_out[FLAG_C] = ((act == ACT_RLCA) || (act == ACT_RLA)) ? acc_in[7]
                                                                          : acc_in[0];
         end
         ACT_ADD16: begin
            wide_result       = w16;
            flags_out         = keep_szp;
            flags_out[FLAG_Y] = w16[BYTE_W + FLAG_Y];
            flags_out[FLAG_X] = w16[BYTE_W + FLAG_X];
            // half carry out of bit 11
            flags_out[FLAG_H] = wide_left[12] ^ wide_right[12] ^ w16[12];
            flags_out[FLAG_C] = sum17[WIDE_W];
         end
         default: begin
            result    = acc_in;
            flags_out = flags_in;
         end
      endcase
   end

endmodule

### rtl/accumulator_alu_with_flags.sv
// -----------------------------------------------------------------------------
// accumulator_alu_with_flags
// Eight-bit accumulator ALU with flags and a 16-bit add, two register stages.
// -----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one operation word: action code, accumulator,
//   flag byte, byte operand and two 16-bit operands. A word is taken at a
//   clock edge with req_valid high and req_stall low.
//   The rsp_ channel returns exactly one word per request, in order: new byte
//   value, new flag byte and the 16-bit sum (zero unless the action is add16).
//   The request is registered in the input stage at the edge that takes it.
//   From there the whole ALU is evaluated in one pass into the result
//   register, which drives rsp_valid and the response word. One word is
//   accepted every cycle while the receiver takes them.
//   If rsp_stall is held, the result register holds its word, the input
//   register still takes one more request, and req_stall rises only when both
//   stages are full.
//   Synchronous reset empties both stages; no result is pending afterwards.
//   Unused action codes return the accumulator and flags unchanged.
// -----------------------------------------------------------------------------
module accumulator_alu_with_flags
   import acc_alu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [BYTE_W-1:0]   req_acc_in,
   input  logic [BYTE_W-1:0]   req_flags_in,
   input  logic [BYTE_W-1:0]   req_operand,
   input  logic [WIDE_W-1:0]   req_wide_left,
   input  logic [WIDE_W-1:0]   req_wide_right,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_result,
   output logic [BYTE_W-1:0]   rsp_flags_out,
   output logic [WIDE_W-1:0]   rsp_wide_result
);

   logic                s1_valid_ff, s1_valid_in;
   logic [ACTION_W-1:0] s1_action_ff;
   logic [BYTE_W-1:0]   s1_acc_ff;
   logic [BYTE_W-1:0]   s1_flags_ff;
   logic [BYTE_W-1:0]   s1_operand_ff;
   logic [WIDE_W-1:0]   s1_wide_left_ff;
   logic [WIDE_W-1:0]   s1_wide_right_ff;
   logic                s1_load;

   logic                s2_valid_ff, s2_valid_in;
   logic [BYTE_W-1:0]   s2_result_ff, s2_result_in;
   logic [BYTE_W-1:0]   s2_flags_ff, s2_flags_in;
   logic [WIDE_W-1:0]   s2_wide_ff, s2_wide_in;
   logic                s2_load;

   // result stage moves when empty or when its word is taken
   assign s2_load     = !s2_valid_ff || !rsp_stall;
   assign s1_load     = !s1_valid_ff || s2_load;
   assign req_stall   = !s1_load;
   assign s1_valid_in = s1_load ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;

   acc_alu_core u_core (
      .action      (s1_action_ff),
      .acc_in      (s1_acc_ff),
      .flags_in    (s1_flags_ff),
      .operand     (s1_operand_ff),
      .wide_left   (s1_wide_left_ff),
      .wide_right  (s1_wide_right_ff),
      .result      (s2_result_in),
      .flags_out   (s2_flags_in),
      .wide_result (s2_wide_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         s1_action_ff     <= req_action;
         s1_acc_ff        <= req_acc_in;
         s1_flags_ff      <= req_flags_in;
         s1_operand_ff    <= req_operand;
         s1_wide_left_ff  <= req_wide_left;
         s1_wide_right_ff <= req_wide_right;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         s2_result_ff <= s2_result_in;
         s2_flags_ff  <= s2_flags_in;
         s2_wide_ff   <= s2_wide_in;
      end
   end

   assign rsp_valid       = s2_valid_ff;
   assign rsp_result      = s2_result_ff;
   assign rsp_flags_out   = s2_flags_ff;
   assign rsp_wide_result = s2_wide_ff;

endmodule

### rtl/acc_alu_checker.sv
// -----------------------------------------------------------------------------
// acc_alu_checker
// Port-level checks on the accumulator ALU, bound to the top level.
// -----------------------------------------------------------------------------
module acc_alu_checker
   import acc_alu_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [BYTE_W-1:0]   rsp_result,
   input logic [BYTE_W-1:0]   rsp_flags_out,
   input logic [WIDE_W-1:0]   rsp_wide_result
);

   // nothing pending just after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word shown straight after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result)
         && $stable(rsp_flags_out) && $stable(rsp_wide_result))
      else $error("stalled result word changed");

   // an empty result side never holds back requests
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with result stage empty");

   // after a request is taken, a valid result word is on the output behind the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("accepted word did not arrive at the output");

   // a non-zero wide sum only comes from add16, which clears the subtract flag
   a_wide_n: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_wide_result != '0) |-> !rsp_flags_out[FLAG_N])
      else $error("wide sum with subtract flag set");

endmodule

bind accumulator_alu_with_flags acc_alu_checker u_acc_alu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result      (rsp_result),
   .rsp_flags_out   (rsp_flags_out),
   .rsp_wide_result (rsp_wide_result)
);

### dv/alu_flag_checker.sv
// -----------------------------------------------------------------------------
// alu_flag_checker
// Watches both channels of the accumulator ALU. Every accepted request word is
// turned into its predicted result and flag byte, and each accepted response
// word is compared field by field with the oldest prediction still waiting.
// -----------------------------------------------------------------------------
module alu_flag_checker
   import acc_alu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [BYTE_W-1:0]   req_acc_in,
   input  logic [BYTE_W-1:0]   req_flags_in,
   input  logic [BYTE_W-1:0]   req_operand,
   input  logic [WIDE_W-1:0]   req_wide_left,
   input  logic [WIDE_W-1:0]   req_wide_right,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [BYTE_W-1:0]   rsp_result,
   input  logic [BYTE_W-1:0]   rsp_flags_out,
   input  logic [WIDE_W-1:0]   rsp_wide_result,
   output int                  fail_count,
   output int                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [BYTE_W-1:0] MASK_S  = 8'h01 << FLAG_S;
   localparam logic [BYTE_W-1:0] MASK_Z  = 8'h01 << FLAG_Z;
   localparam logic [BYTE_W-1:0] MASK_Y  = 8'h01 << FLAG_Y;
   localparam logic [BYTE_W-1:0] MASK_H  = 8'h01 << FLAG_H;
   localparam logic [BYTE_W-1:0] MASK_X  = 8'h01 << FLAG_X;
   localparam logic [BYTE_W-1:0] MASK_P  = 8'h01 << FLAG_P;
   localparam logic [BYTE_W-1:0] MASK_N  = 8'h01 << FLAG_N;
   localparam logic [BYTE_W-1:0] MASK_C  = 8'h01 << FLAG_C;
   localparam logic [BYTE_W-1:0] MASK_YX = MASK_Y | MASK_X;
   localparam logic [BYTE_W-1:0] MASK_SZP = MASK_S | MASK_Z | MASK_P;

   typedef struct packed {
      logic [BYTE_W-1:0] result;
      logic [BYTE_W-1:0] flags;
      logic [WIDE_W-1:0] wide;
   } alu_word_type;

   alu_word_type predicted_words[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic logic [BYTE_W-1:0] sz_yx(input logic [BYTE_W-1:0] r);
      return (r & (MASK_S | MASK_YX)) | ((r == 8'h00) ? MASK_Z : 8'h00);
   endfunction

   // {flags, byte} of the shared byte adder
   function automatic logic [2*BYTE_W-1:0] add_sub(input logic [BYTE_W-1:0] a, v,
                                                   input logic cin, sub);
      logic [BYTE_W:0]   full;
      logic [BYTE_W-1:0] r, f;
      full = sub ? ({1'b0, a} - {1'b0, v} - 9'(cin)) : ({1'b0, a} + {1'b0, v} + 9'(cin));
      r    = full[BYTE_W-1:0];
      f    = sz_yx(r);
      f[FLAG_P] = sub ? ((a[7] ^ v[7]) & (a[7] ^ r[7])) : (~(a[7] ^ v[7]) & (a[7] ^ r[7]));
      f[FLAG_N] = sub;
      f[FLAG_H] = a[4] ^ v[4] ^ r[4];
      f[FLAG_C] = full[BYTE_W];
      return {f, r};
   endfunction

   function automatic alu_word_type alu_outcome(input logic [ACTION_W-1:0] action,
                                                input logic [BYTE_W-1:0] a, fin, v,
                                                input logic [WIDE_W-1:0] wl, wr);
      alu_word_type        w;
      logic [2*BYTE_W-1:0] fr;
      logic [BYTE_W-1:0]  diff;
      logic               carry, half, t;
      logic [WIDE_W:0]    sum;
      w.result = a;
      w.flags  = fin;
      w.wide   = '0;
      case (action_type'(action))
         ACT_ADD: {w.flags, w.result} = add_sub(a, v, 1'b0, 1'b0);
         ACT_ADC: {w.flags, w.result} = add_sub(a, v, fin[FLAG_C], 1'b0);
         ACT_SUB: {w.flags, w.result} = add_sub(a, v, 1'b0, 1'b1);
         ACT_SBC: {w.flags, w.result} = add_sub(a, v, fin[FLAG_C], 1'b1);
         ACT_AND: begin
            w.result = a & v;
            w.flags  = sz_yx(w.result) | MASK_H;
            w.flags[FLAG_P] = ~^w.result;
         end
         ACT_XOR: begin
            w.result = a ^ v;
            w.flags  = sz_yx(w.result);
            w.flags[FLAG_P] = ~^w.result;
         end
         ACT_OR: begin
            w.result = a | v;
            w.flags  = sz_yx(w.result);
            w.flags[FLAG_P] = ~^w.result;
         end
         ACT_CP: begin
            // undocumented bits follow the operand, not the difference
            fr      = add_sub(a, v, 1'b0, 1'b1);
            w.flags = (fr[2*BYTE_W-1:BYTE_W] & ~MASK_YX) | (v & MASK_YX);
         end
         ACT_INC: begin
            w.result = v + 8'd1;
            w.flags  = sz_yx(w.result) | (fin & MASK_C);
            w.flags[FLAG_P] = (w.result == INC_OVF_VALUE);
            w.flags[FLAG_H] = (w.result[3:0] == 4'h0);
         end
         ACT_DEC: begin
            w.result = v - 8'd1;
            w.flags  = sz_yx(w.result) | (fin & MASK_C) | MASK_N;
            w.flags[FLAG_P] = (w.result == DEC_OVF_VALUE);
            w.flags[FLAG_H] = (w.result[3:0] == 4'hf);
         end
         ACT_DAA: begin
            diff  = 8'h00;
            carry = 1'b0;
            if (fin[FLAG_C] || a > DAA_HIGH_LIMIT) begin
               diff  = DAA_HIGH_ADJ;
               carry = 1'b1;
            end
            if (fin[FLAG_H] || a[3:0] > DAA_LOW_LIMIT) diff = diff + DAA_LOW_ADJ;
            if (fin[FLAG_N]) begin
               half     = fin[FLAG_H] && (a[3:0] <= DAA_SUB_LIMIT);
               w.result = a - diff;
            end else begin
               half     = (a[3:0] > DAA_LOW_LIMIT);
               w.result = a + diff;
            end
            w.flags = sz_yx(w.result) | (fin & MASK_N);
            w.flags[FLAG_P] = ~^w.result;
            w.flags[FLAG_H] = half;
            w.flags[FLAG_C] = carry;
         end
         ACT_CPL: begin
            w.result = ~a;
            w.flags  = (fin & (MASK_SZP | MASK_C)) | MASK_H | MASK_N | (w.result & MASK_YX);
         end
         ACT_SCF: w.flags = (fin & MASK_SZP) | MASK_C | (a & MASK_YX);
         ACT_CCF: begin
            w.flags = (fin & MASK_SZP) | (a & MASK_YX);
            w.flags[FLAG_H] = fin[FLAG_C];
            w.flags[FLAG_C] = ~fin[FLAG_C];
         end
         ACT_RLCA, ACT_RLA: begin
            t        = (action == ACT_RLCA) ? a[7] : fin[FLAG_C];
            w.result = {a[6:0], t};
            w.flags  = (fin & MASK_SZP) | (w.result & MASK_YX);
            w.flags[FLAG_C] = a[7];
         end
         ACT_RRCA, ACT_RRA: begin
            t        = (action == ACT_RRCA) ? a[0] : fin[FLAG_C];
            w.result = {t, a[7:1]};
            w.flags  = (fin & MASK_SZP) | (w.result & MASK_YX);
            w.flags[FLAG_C] = a[0];
         end
         ACT_ADD16: begin
            sum     = {1'b0, wl} + {1'b0, wr};
            w.wide  = sum[WIDE_W-1:0];
            w.flags = (fin & MASK_SZP) | (sum[15:8] & MASK_YX);
            w.flags[FLAG_H] = wl[12] ^ wr[12] ^ sum[12];
            w.flags[FLAG_C] = sum[WIDE_W];
         end
         default: ;
      endcase
      return w;
   endfunction

   always @(posedge clock) begin
      alu_word_type want;
      int           errs;
      errs = 0;
      if (!reset && req_valid && !req_stall)
         predicted_words.push_back(alu_outcome(req_action, req_acc_in, req_flags_in,
                                               req_operand, req_wide_left, req_wide_right));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_words.size() == 0) begin
            $error("response word arrived with no request outstanding");
            errs++;
         end else begin
            want = predicted_words.pop_front();
            if (rsp_result !== want.result) begin
               $error("rsp_result: expected %h, got %h", want.result, rsp_result);
               errs++;
            end
            if (rsp_flags_out !== want.flags) begin
               $error("rsp_flags_out: expected %h, got %h", want.flags, rsp_flags_out);
               errs++;
            end
            if (rsp_wide_result !== want.wide) begin
               $error("rsp_wide_result: expected %h, got %h", want.wide, rsp_wide_result);
               errs++;
            end
         end
      end
      fail_count <= fail_count + errs;
      pending    <= predicted_words.size();
   end

endmodule

### dv/tb_accumulator_alu_with_flags.sv
// -----------------------------------------------------------------------------
// tb_accumulator_alu_with_flags
// Drives directed and random operation words into the accumulator ALU with
// random idling on both channels; the checker beside the block predicts and
// compares every response word.
// -----------------------------------------------------------------------------
module tb_accumulator_alu_with_flags;
   timeunit 1ns;
   timeprecision 1ps;

   import acc_alu_pkg::*;

   localparam int RANDOM_WORDS   = 1200;
   localparam int CALM_TAIL      = 200;
   localparam int WATCHDOG_LIMIT = 1000;

   localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 5'd19;
   localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 5'd31;

   localparam logic [BYTE_W-1:0] F_CARRY = 8'h01 << FLAG_C;
   localparam logic [BYTE_W-1:0] F_HALF  = 8'h01 << FLAG_H;
   localparam logic [BYTE_W-1:0] F_SUB   = 8'h01 << FLAG_N;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action     = '0;
   logic [BYTE_W-1:0]   req_acc_in     = '0;
   logic [BYTE_W-1:0]   req_flags_in   = '0;
   logic [BYTE_W-1:0]   req_operand    = '0;
   logic [WIDE_W-1:0]   req_wide_left  = '0;
   logic [WIDE_W-1:0]   req_wide_right = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [BYTE_W-1:0]   rsp_result;
   logic [BYTE_W-1:0]   rsp_flags_out;
   logic [WIDE_W-1:0]   rsp_wide_result;

   int fail_count;
   int pending;
   int stall_left   = 0;
   int quiet_cycles = 0;
   bit calm         = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   accumulator_alu_with_flags dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_acc_in      (req_acc_in),
      .req_flags_in    (req_flags_in),
      .req_operand     (req_operand),
      .req_wide_left   (req_wide_left),
      .req_wide_right  (req_wide_right),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_flags_out   (rsp_flags_out),
      .rsp_wide_result (rsp_wide_result)
   );

   alu_flag_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_acc_in      (req_acc_in),
      .req_flags_in    (req_flags_in),
      .req_operand     (req_operand),
      .req_wide_left   (req_wide_left),
      .req_wide_right  (req_wide_right),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_flags_out   (rsp_flags_out),
      .rsp_wide_result (rsp_wide_result),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // receiver back-pressure in bursts
   always @(posedge clock) begin
      if (reset || calm) stall_left = 0;
      else if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 19);
      rsp_stall <= (stall_left > 0);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // returns at the edge where the word is taken
   task automatic send_word(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] acc,
                            input logic [BYTE_W-1:0] flg, opd,
                            input logic [WIDE_W-1:0] wl, wr);
      req_valid      <= 1'b1;
      req_action     <= act;
      req_acc_in     <= acc;
      req_flags_in   <= flg;
      req_operand    <= opd;
      req_wide_left  <= wl;
      req_wide_right <= wr;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic sender_gap();
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 11))
         0:       return 8'h00;
         1:       return 8'hff;
         2:       return 8'h80;
         3:       return 8'h7f;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [WIDE_W-1:0] pick_wide();
      case ($urandom_range(0, 11))
         0:       return 16'h0000;
         1:       return 16'hffff;
         2:       return 16'h0fff;
         3:       return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [ACTION_W-1:0] pick_action();
      if ($urandom_range(0, 24) == 0)
         return ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
      return ACTION_W'($urandom_range(ACT_ADD, ACT_ADD16));
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_word(ACT_ADD,   8'hff, 8'h00, 8'h01, 16'hffff, 16'hffff);
      send_word(ACT_ADC,   8'h7f, 8'hff, 8'h00, 16'h0000, 16'h0000);
      send_word(ACT_SUB,   8'h80, 8'hff, 8'h01, 16'h0000, 16'h0000);
      send_word(ACT_SBC,   8'h00, F_CARRY, 8'hff, 16'h0000, 16'h0000);
      send_word(ACT_AND,   8'hff, 8'h00, 8'hff, 16'h0000, 16'h0000);
      send_word(ACT_XOR,   8'h5a, 8'hff, 8'h5a, 16'h0000, 16'h0000);
      send_word(ACT_OR,    8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000);
      // compare takes its copied bits from the operand
      send_word(ACT_CP,    8'h10, 8'h00, 8'h28, 16'h0000, 16'h0000);
      send_word(ACT_INC,   8'h00, 8'h00, 8'h7f, 16'h0000, 16'h0000);
      send_word(ACT_INC,   8'h00, 8'hff, 8'hff, 16'h0000, 16'h0000);
      send_word(ACT_DEC,   8'hff, 8'hff, 8'h80, 16'h0000, 16'h0000);
      send_word(ACT_DEC,   8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000);
      send_word(ACT_DAA,   8'h9a, 8'h00, 8'h00, 16'h0000, 16'h0000);
      send_word(ACT_DAA,   8'h0f, F_HALF, 8'h00, 16'h0000, 16'h0000);
      send_word(ACT_DAA,   8'h05, F_SUB | F_HALF, 8'h00, 16'h0000, 16'h0000);
      send_word(ACT_DAA,   8'h66, F_SUB | F_HALF | F_CARRY, 8'h00, 16'h0000, 16'h0000);
      send_word(ACT_CPL,   8'h00, 8'hff, 8'h00, 16'h0000, 16'h0000);
      send_word(ACT_SCF,   8'h28, 8'h00, 8'h00, 16'h0000, 16'h0000);
      send_word(ACT_CCF,   8'hff, F_CARRY, 8'h00, 16'h0000, 16'h0000);
      send_word(ACT_CCF,   8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000);
      send_word(ACT_RLCA,  8'h80, 8'h00, 8'h00, 16'h0000, 16'h0000);
      send_word(ACT_RRCA,  8'h01, 8'h00, 8'h00, 16'h0000, 16'h0000);
      send_word(ACT_RLA,   8'h80, F_CARRY, 8'h00, 16'h0000, 16'h0000);
      send_word(ACT_RRA,   8'h01, 8'h00, 8'h00, 16'h0000, 16'h0000);
      send_word(ACT_ADD16, 8'h55, 8'hff, 8'h00, 16'hffff, 16'h0001);
      send_word(ACT_ADD16, 8'haa, 8'h00, 8'h00, 16'h0fff, 16'h0001);
      send_word(ACT_SPARE_FIRST, 8'h3c, 8'ha5, 8'hff, 16'hffff, 16'hffff);
      send_word(ACT_SPARE_LAST,  8'hc3, 8'h5a, 8'h00, 16'h1234, 16'h4321);
      wait_for_results();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 100 == 0)
            calm <= (i >= RANDOM_WORDS - CALM_TAIL) || ($urandom_range(0, 4) == 0);
         send_word(pick_action(), pick_byte(), 8'($urandom), pick_byte(),
                   pick_wide(), pick_wide());
         if (i % 300 == 299) wait_for_results();
         else sender_gap();
      end

      wait_for_results();
      repeat (3) @(posedge clock);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

### files.f
rtl/acc_alu_pkg.sv
rtl/acc_alu_core.sv
rtl/accumulator_alu_with_flags.sv
rtl/acc_alu_checker.sv
dv/alu_flag_checker.sv
dv/tb_accumulator_alu_with_flags.sv
